// ----- hdl/sorted_range_registry_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted range registry
// Shared forms of concurrent assertions, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_RANGE_REGISTRY_TOP_MACROS_SVH
`define SORTED_RANGE_REGISTRY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/srr_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted range registry package
// Operation and status codes and the field widths of the stream channels.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int unsigned DEFAULT_CAPACITY = 256;

    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 32;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 16;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_IGNORED   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

endpackage

// ----- hdl/sorted_range_registry_top.sv -----
// ----------------------------------------------------------------------------
// Sorted range registry
// Table of (base, size) regions kept sorted by base, with insert, remove by
// base and a span containment lookup.
// ----------------------------------------------------------------------------
// The block takes one operation at a time and returns exactly one result for
// each. All work goes through a table memory with one write port and one
// registered read port, so the data of every table read is registered
// before it is used. A lower-bound binary search finds the slot for the
// address. On top of that a query needs up to two probe reads and span
// arithmetic, a subtraction and then an evaluation. An insert reads and
// writes each entry that moves up, then writes the new region; a remove
// reads and writes each entry that moves down, then lowers the count.
// Operations that are ignored or dropped at once go straight from idle to the
// result state. The input side is ready only when the sequencer is idle; the
// result sits in an output register, so a new operation may be taken while
// the previous result still waits for its transfer. The table memory needs
// no clearing after reset: only entries below the region count are read.
module sorted_range_registry_top #(
    parameter int unsigned CAPACITY = srr_pkg::DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Operation channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata fields from bit 0: address [63:0], length [95:64].
    input  logic [srr_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser fields from bit 0: op [1:0].
    input  logic [srr_pkg::OP_W-1:0]      s_tuser,

    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata fields from bit 0: contained [0], status [2:1], entry_count [11:3],
    // zero fill [15:12].
    output logic [srr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W    = srr_pkg::ADDR_W;
    localparam int LEN_W     = srr_pkg::LEN_W;
    localparam int OUT_CNT_W = srr_pkg::COUNT_OUT_W;
    localparam int PAD_W     = srr_pkg::M_TDATA_W - OUT_CNT_W - srr_pkg::STAT_W - 1;
    // The count must hold CAPACITY itself; an index only reaches CAPACITY - 1.
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHUP_RD,
        S_SHUP_WR,
        S_INS_WR,
        S_RM_RD,
        S_RM_CMP,
        S_SHDN_RD,
        S_SHDN_WR,
        S_Q_RD,
        S_Q_CMP,
        S_Q_SUB,
        S_Q_EVAL,
        S_DONE
    } state_t;

    // Region table: one write port and one registered read port.
    logic [ADDR_W-1:0] base_mem [CAPACITY];
    logic [LEN_W-1:0]  size_mem [CAPACITY];

    state_t                      state_reg;
    logic [srr_pkg::OP_W-1:0]    op_reg;
    logic [ADDR_W-1:0]           addr_reg;
    logic [LEN_W-1:0]            len_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            lo_reg;
    logic [CNT_W-1:0]            hi_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic                        fallback_reg;
    logic                        contained_reg;
    logic [srr_pkg::STAT_W-1:0]  status_reg;
    logic [ADDR_W-1:0]           rd_base_reg;
    logic [LEN_W-1:0]            rd_size_reg;
    logic [ADDR_W:0]             diff_reg;
    logic [LEN_W:0]              slack_reg;
    logic                        m_tvalid_reg;
    logic [srr_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [ADDR_W-1:0] in_addr;
    logic [LEN_W-1:0]  in_len;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  lo_dec;
    logic              search_done;
    logic [IDX_W-1:0]  rd_idx;
    logic              mem_we;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_base;
    logic [LEN_W-1:0]  wr_size;
    logic [srr_pkg::STAT_W-1:0] early_status;
    logic              early_done;

    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_len  = s_tdata[ADDR_W+LEN_W-1:ADDR_W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Midpoint of the current search window, computed without overflow.
    assign mid         = CNT_W'(lo_reg + ((hi_reg - lo_reg) >> 1));
    assign idx_dec     = CNT_W'(idx_reg - 1'b1);
    assign idx_inc     = CNT_W'(idx_reg + 1'b1);
    assign lo_dec      = CNT_W'(lo_reg - 1'b1);
    assign search_done = (lo_reg >= hi_reg);

    // Operations that are settled on arrival, before any table access: zero
    // fields, an empty table, a full table on insert and the unused op code.
    always_comb begin
        early_status = srr_pkg::STAT_DONE;
        early_done   = 1'b0;
        priority if (s_tuser == srr_pkg::OP_INSERT) begin
            if (in_addr == '0 || in_len == '0) begin
                early_status = srr_pkg::STAT_IGNORED;
                early_done   = 1'b1;
            end else if (count_reg >= CAP_CNT) begin
                early_status = srr_pkg::STAT_FULL;
                early_done   = 1'b1;
            end
        end else if (s_tuser == srr_pkg::OP_REMOVE) begin
            if (in_addr == '0 || count_reg == '0) begin
                early_status = srr_pkg::STAT_IGNORED;
                early_done   = 1'b1;
            end
        end else if (s_tuser == srr_pkg::OP_QUERY) begin
            if (in_addr == '0 || in_len == '0 || count_reg == '0) begin
                early_status = srr_pkg::STAT_IGNORED;
                early_done   = 1'b1;
            end
        end else begin
            early_status = srr_pkg::STAT_IGNORED;
            early_done   = 1'b1;
        end
    end

    // Read address for the state that issues a read. Every index driven here
    // lies below the region count whenever its data is used. The query keeps
    // its address through the compare so the data stays for the subtraction.
    always_comb begin
        unique case (state_reg)
            S_SRCH_RD:       rd_idx = mid[IDX_W-1:0];
            S_SHUP_RD:       rd_idx = idx_dec[IDX_W-1:0];
            S_RM_RD:         rd_idx = lo_reg[IDX_W-1:0];
            S_SHDN_RD:       rd_idx = idx_inc[IDX_W-1:0];
            S_Q_RD, S_Q_CMP: rd_idx = idx_reg[IDX_W-1:0];
            default:         rd_idx = '0;
        endcase
    end

    // Write port: shifted entries during moves, the new region on insert.
    always_comb begin
        mem_we  = 1'b0;
        wr_idx  = idx_reg[IDX_W-1:0];
        wr_base = rd_base_reg;
        wr_size = rd_size_reg;
        unique case (state_reg)
            S_SHUP_WR, S_SHDN_WR: begin
                mem_we = 1'b1;
            end
            S_INS_WR: begin
                mem_we  = 1'b1;
                wr_idx  = lo_reg[IDX_W-1:0];
                wr_base = addr_reg;
                wr_size = len_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            base_mem[wr_idx] <= wr_base;
            size_mem[wr_idx] <= wr_size;
        end
        rd_base_reg <= base_mem[rd_idx];
        rd_size_reg <= size_mem[rd_idx];
    end

    // Sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A new result is loaded when the register is free or is being
            // emptied in this same cycle.
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg        <= s_tuser;
                        addr_reg      <= in_addr;
                        len_reg       <= in_len;
                        contained_reg <= 1'b0;
                        status_reg    <= early_status;
                        lo_reg        <= '0;
                        hi_reg        <= count_reg;
                        state_reg     <= early_done ? S_DONE : S_SRCH_RD;
                    end
                end

                // Lower-bound search: lo ends at the first base >= address.
                S_SRCH_RD: begin
                    if (!search_done) begin
                        state_reg <= S_SRCH_CMP;
                    end else begin
                        priority if (op_reg == srr_pkg::OP_INSERT) begin
                            idx_reg   <= count_reg;
                            state_reg <= S_SHUP_RD;
                        end else if (op_reg == srr_pkg::OP_REMOVE) begin
                            if (lo_reg >= count_reg) begin
                                status_reg <= srr_pkg::STAT_NOT_FOUND;
                                state_reg  <= S_DONE;
                            end else begin
                                state_reg <= S_RM_RD;
                            end
                        end else begin
                            // Past the end, the candidate is the last entry.
                            if (lo_reg < count_reg) begin
                                idx_reg      <= lo_reg;
                                fallback_reg <= 1'b0;
                            end else begin
                                idx_reg      <= lo_dec;
                                fallback_reg <= 1'b1;
                            end
                            state_reg <= S_Q_RD;
                        end
                    end
                end

                S_SRCH_CMP: begin
                    if (rd_base_reg < addr_reg) begin
                        lo_reg <= CNT_W'(mid + 1'b1);
                    end else begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_SRCH_RD;
                end

                // Insert: move entries at and above the slot up by one.
                S_SHUP_RD: begin
                    if (idx_reg > lo_reg) begin
                        state_reg <= S_SHUP_WR;
                    end else begin
                        state_reg <= S_INS_WR;
                    end
                end

                S_SHUP_WR: begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_SHUP_RD;
                end

                S_INS_WR: begin
                    count_reg <= CNT_W'(count_reg + 1'b1);
                    state_reg <= S_DONE;
                end

                // Remove: only an exact base match is deleted.
                S_RM_RD: begin
                    state_reg <= S_RM_CMP;
                end

                S_RM_CMP: begin
                    if (rd_base_reg != addr_reg) begin
                        status_reg <= srr_pkg::STAT_NOT_FOUND;
                        state_reg  <= S_DONE;
                    end else begin
                        idx_reg   <= lo_reg;
                        state_reg <= S_SHDN_RD;
                    end
                end

                S_SHDN_RD: begin
                    if (idx_inc < count_reg) begin
                        state_reg <= S_SHDN_WR;
                    end else begin
                        count_reg <= CNT_W'(count_reg - 1'b1);
                        state_reg <= S_DONE;
                    end
                end

                S_SHDN_WR: begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_SHDN_RD;
                end

                // Query: an exact base match is used as is, otherwise the
                // entry just below the lower bound.
                S_Q_RD: begin
                    state_reg <= S_Q_CMP;
                end

                S_Q_CMP: begin
                    if (fallback_reg || rd_base_reg == addr_reg) begin
                        state_reg <= S_Q_SUB;
                    end else if (idx_reg == '0) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg      <= idx_dec;
                        fallback_reg <= 1'b1;
                        state_reg    <= S_Q_RD;
                    end
                end

                // Borrows flag a span start below the base or a span longer
                // than the region.
                S_Q_SUB: begin
                    diff_reg  <= {1'b0, addr_reg} - {1'b0, rd_base_reg};
                    slack_reg <= {1'b0, rd_size_reg} - {1'b0, len_reg};
                    state_reg <= S_Q_EVAL;
                end

                S_Q_EVAL: begin
                    if (!diff_reg[ADDR_W] && !slack_reg[LEN_W]) begin
                        contained_reg <= (diff_reg[ADDR_W-1:0]
                                          <= ADDR_W'(slack_reg[LEN_W-1:0]));
                    end
                    state_reg <= S_DONE;
                end

                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {{PAD_W{1'b0}}, OUT_CNT_W'(count_reg),
                                         status_reg, contained_reg};
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/srr_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted range registry checker
// Port-level assertions on the operation and result channels.
// ----------------------------------------------------------------------------
`include "sorted_range_registry_top_macros.svh"

module srr_checker #(
    parameter int unsigned CAPACITY = srr_pkg::DEFAULT_CAPACITY
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [srr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [srr_pkg::COUNT_OUT_W-1:0] CAP_OUT = srr_pkg::COUNT_OUT_W'(CAPACITY);

    // A pending result is not withdrawn.
    `SRR_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // One operation at a time: a transfer on the input closes the input.
    `SRR_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input open during operation")

    // A dropped insert reports a full table.
    `SRR_ASSERT_NOW(a_full_count, m_tvalid && m_tdata[2:1] == srr_pkg::STAT_FULL, m_tdata[11:3] == CAP_OUT, "full status with table not full")

    // A hit only comes with a completed query.
    `SRR_ASSERT_NOW(a_hit_done, m_tvalid && m_tdata[0], m_tdata[2:1] == srr_pkg::STAT_DONE, "hit with non-done status")

endmodule

bind sorted_range_registry_top srr_checker #(.CAPACITY(CAPACITY)) u_srr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
